// ----- rtl/md2_pkg.sv -----
// Shared types, constants and the pi S-table for the MD2 digest block.
package md2_pkg;

	localparam int BLK_BYTES   = 16;
	localparam int STATE_BYTES = 48;
	localparam int ROUNDS      = 18;

	localparam logic [7:0] PI_SBOX [256] = '{
		8'd41, 8'd46, 8'd67, 8'd201, 8'd162, 8'd216, 8'd124, 8'd1, 8'd61, 8'd54, 8'd84, 8'd161,
		8'd236, 8'd240, 8'd6, 8'd19, 8'd98, 8'd167, 8'd5, 8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
		8'd152, 8'd147, 8'd43, 8'd217, 8'd188, 8'd76, 8'd130, 8'd202, 8'd30, 8'd155, 8'd87, 8'd60,
		8'd253, 8'd212, 8'd224, 8'd22, 8'd103, 8'd66, 8'd111, 8'd24, 8'd138, 8'd23, 8'd229, 8'd18,
		8'd190, 8'd78, 8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73, 8'd160, 8'd251, 8'd245,
		8'd142, 8'd187, 8'd47, 8'd238, 8'd122, 8'd169, 8'd104, 8'd121, 8'd145, 8'd21, 8'd178,
		8'd7, 8'd63, 8'd148, 8'd194, 8'd16, 8'd137, 8'd11, 8'd34, 8'd95, 8'd33, 8'd128, 8'd127,
		8'd93, 8'd154, 8'd90, 8'd144, 8'd50, 8'd39, 8'd53, 8'd62, 8'd204, 8'd231, 8'd191, 8'd247,
		8'd151, 8'd3, 8'd255, 8'd25, 8'd48, 8'd179, 8'd72, 8'd165, 8'd181, 8'd209, 8'd215, 8'd94,
		8'd146, 8'd42, 8'd172, 8'd86, 8'd170, 8'd198, 8'd79, 8'd184, 8'd56, 8'd210, 8'd150,
		8'd164, 8'd125, 8'd182, 8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4, 8'd241,
		8'd69, 8'd157, 8'd112, 8'd89, 8'd100, 8'd113, 8'd135, 8'd32, 8'd134, 8'd91, 8'd207,
		8'd101, 8'd230, 8'd45, 8'd168, 8'd2, 8'd27, 8'd96, 8'd37, 8'd173, 8'd174, 8'd176, 8'd185,
		8'd246, 8'd28, 8'd70, 8'd97, 8'd105, 8'd52, 8'd64, 8'd126, 8'd15, 8'd85, 8'd71, 8'd163,
		8'd35, 8'd221, 8'd81, 8'd175, 8'd58, 8'd195, 8'd92, 8'd249, 8'd206, 8'd186, 8'd197,
		8'd234, 8'd38, 8'd44, 8'd83, 8'd13, 8'd110, 8'd133, 8'd40, 8'd132, 8'd9, 8'd211, 8'd223,
		8'd205, 8'd244, 8'd65, 8'd129, 8'd77, 8'd82, 8'd106, 8'd220, 8'd55, 8'd200, 8'd108,
		8'd193, 8'd171, 8'd250, 8'd36, 8'd225, 8'd123, 8'd8, 8'd12, 8'd189, 8'd177, 8'd74,
		8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99, 8'd232, 8'd109, 8'd233, 8'd203, 8'd213,
		8'd254, 8'd59, 8'd0, 8'd29, 8'd57, 8'd242, 8'd239, 8'd183, 8'd14, 8'd102, 8'd88, 8'd208,
		8'd228, 8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75, 8'd10, 8'd49, 8'd68,
		8'd80, 8'd180, 8'd143, 8'd237, 8'd31, 8'd26, 8'd219, 8'd153, 8'd141, 8'd51, 8'd159,
		8'd17, 8'd131, 8'd20
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_OUT
	} md2_state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_ROUND,
		OP_ROTATE,
		OP_CLEAR
	} md2_op_t;

	typedef struct packed {
		md2_op_t    op;
		logic       src_ck;
		logic       buf_wr;
		logic [7:0] buf_din;
		logic       rnd_end;
		logic [4:0] rnd;
	} md2_ctl_t;

	function automatic logic [7:0] md2_sbox(input logic [7:0] idx);
		return PI_SBOX[idx];
	endfunction

endpackage

// ----- rtl/md2_chk_unit.sv -----
// Block buffer and running checksum, both as byte-wide shift rings.
module md2_chk_unit
	import md2_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  md2_ctl_t   ctl,
	output logic [7:0] src_byte
);

	logic [7:0] buf_q [BLK_BYTES];
	logic [7:0] ck_q  [BLK_BYTES];
	logic [7:0] carry_q;
	logic [7:0] ck_new;

	assign ck_new   = ck_q[0] ^ md2_sbox(buf_q[0] ^ carry_q);
	assign src_byte = ctl.src_ck ? ck_q[0] : buf_q[0];

	always_ff @(posedge clk) begin
		if (ctl.buf_wr) begin
			for (int i = 0; i < BLK_BYTES - 1; i++) buf_q[i] <= buf_q[i + 1];
			buf_q[BLK_BYTES - 1] <= ctl.buf_din;
		end else if (ctl.op == OP_LOAD && !ctl.src_ck) begin
			for (int i = 0; i < BLK_BYTES - 1; i++) buf_q[i] <= buf_q[i + 1];
			buf_q[BLK_BYTES - 1] <= buf_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ck_q    <= '{default: '0};
			carry_q <= '0;
		end else begin
			case (ctl.op)
				OP_LOAD: begin
					for (int i = 0; i < BLK_BYTES - 1; i++) ck_q[i] <= ck_q[i + 1];
					if (ctl.src_ck) begin
						ck_q[BLK_BYTES - 1] <= ck_q[0];
					end else begin
						ck_q[BLK_BYTES - 1] <= ck_new;
						carry_q             <= ck_new;
					end
				end
				OP_CLEAR: begin
					ck_q    <= '{default: '0};
					carry_q <= '0;
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/md2_state_ring.sv -----
// 48-byte compression state ring, one S-table step per cycle.
module md2_state_ring
	import md2_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  md2_ctl_t   ctl,
	input  logic [7:0] src_byte,
	output logic [7:0] head
);

	logic [7:0] st_q [STATE_BYTES];
	logic [7:0] t_q;
	logic [7:0] nxt;

	assign head = st_q[0];
	assign nxt  = st_q[0] ^ md2_sbox(t_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{default: '0};
			t_q  <= '0;
		end else begin
			case (ctl.op)
				OP_LOAD: begin
					// three 16-byte segments shift side by side
					for (int i = 0; i < STATE_BYTES - 1; i++) st_q[i] <= st_q[i + 1];
					st_q[BLK_BYTES - 1]     <= st_q[0];
					st_q[2 * BLK_BYTES - 1] <= src_byte;
					st_q[STATE_BYTES - 1]   <= src_byte ^ st_q[0];
					t_q                     <= '0;
				end
				OP_ROUND: begin
					for (int i = 0; i < STATE_BYTES - 1; i++) st_q[i] <= st_q[i + 1];
					st_q[STATE_BYTES - 1] <= nxt;
					t_q <= ctl.rnd_end ? nxt + {3'b000, ctl.rnd} : nxt;
				end
				OP_ROTATE: begin
					for (int i = 0; i < STATE_BYTES - 1; i++) st_q[i] <= st_q[i + 1];
					st_q[STATE_BYTES - 1] <= st_q[0];
				end
				OP_CLEAR: begin
					st_q <= '{default: '0};
					t_q  <= '0;
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/md2_message_digest.sv -----
// MD2 digest top level: byte-serial sequencer, datapath units and output register.
// A message byte is taken while idle; a full block is then loaded and compressed in 18 rounds.
// The ending item adds up to 16 pad bytes, a compression of the padded block and one of the
// checksum block, then 16 digest beats at one per cycle when out_ready stays high.
// Rate is set by the single S-table step per cycle in the state ring.
// arst_n clears the sequencer, the compression state and the checksum to zero.
module md2_message_digest
	import md2_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       byte_present,
	input  logic       end_of_message,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] digest_byte,
	output logic       digest_last
);

	md2_state_t state_q, state_d;
	logic [5:0] step_q, step_d;
	logic [4:0] rnd_q, rnd_d;
	logic [3:0] fill_q, fill_d;
	logic [4:0] pad_q, pad_d;
	logic       end_q, end_d;
	logic       fin_q, fin_d;
	logic       src_q, src_d;
	logic       out_load;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic [7:0] src_byte;
	logic [7:0] head;
	md2_ctl_t   ctl;

	md2_chk_unit u_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.src_byte (src_byte)
	);

	md2_state_ring u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.src_byte (src_byte),
		.head     (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			rnd_q   <= '0;
			fill_q  <= '0;
			pad_q   <= '0;
			end_q   <= 1'b0;
			fin_q   <= 1'b0;
			src_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			rnd_q   <= rnd_d;
			fill_q  <= fill_d;
			pad_q   <= pad_d;
			end_q   <= end_d;
			fin_q   <= fin_d;
			src_q   <= src_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		step_d      = step_q;
		rnd_d       = rnd_q;
		fill_d      = fill_q;
		pad_d       = pad_q;
		end_d       = end_q;
		fin_d       = fin_q;
		src_d       = src_q;
		in_ready    = 1'b0;
		out_load    = 1'b0;
		ctl.op      = OP_NONE;
		ctl.src_ck  = src_q;
		ctl.buf_wr  = 1'b0;
		ctl.buf_din = {3'b000, pad_q};
		ctl.rnd_end = (step_q == 6'(STATE_BYTES - 1));
		ctl.rnd     = rnd_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					end_d = end_of_message;
					if (byte_present) begin
						ctl.buf_wr  = 1'b1;
						ctl.buf_din = data_byte;
						fill_d      = fill_q + 4'd1;
					end
					if (byte_present && fill_q == 4'(BLK_BYTES - 1)) begin
						state_d = ST_LOAD;
						step_d  = '0;
						src_d   = 1'b0;
					end else if (end_of_message) begin
						state_d = ST_PAD;
						fin_d   = 1'b1;
						pad_d   = 5'(BLK_BYTES) - {1'b0, fill_d};
					end
				end
			end
			ST_PAD: begin
				ctl.buf_wr = 1'b1;
				fill_d     = fill_q + 4'd1;
				if (fill_q == 4'(BLK_BYTES - 1)) begin
					state_d = ST_LOAD;
					step_d  = '0;
					src_d   = 1'b0;
				end
			end
			ST_LOAD: begin
				ctl.op = OP_LOAD;
				step_d = step_q + 6'd1;
				if (step_q == 6'(BLK_BYTES - 1)) begin
					state_d = ST_ROUND;
					step_d  = '0;
					rnd_d   = '0;
				end
			end
			ST_ROUND: begin
				ctl.op = OP_ROUND;
				step_d = step_q + 6'd1;
				if (step_q == 6'(STATE_BYTES - 1)) begin
					step_d = '0;
					rnd_d  = rnd_q + 5'd1;
					if (rnd_q == 5'(ROUNDS - 1)) begin
						if (src_q) begin
							state_d = ST_OUT;
						end else if (fin_q) begin
							state_d = ST_LOAD;
							src_d   = 1'b1;
						end else if (end_q) begin
							state_d = ST_PAD;
							fin_d   = 1'b1;
							pad_d   = 5'(BLK_BYTES);
						end else begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					ctl.op   = OP_ROTATE;
					step_d   = step_q + 6'd1;
					if (step_q == 6'(BLK_BYTES - 1)) begin
						ctl.op  = OP_CLEAR;
						state_d = ST_IDLE;
						step_d  = '0;
						end_d   = 1'b0;
						fin_d   = 1'b0;
						src_d   = 1'b0;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= head;
			out_last_q <= (step_q == 6'(BLK_BYTES - 1));
		end
	end

	assign out_valid   = out_valid_q;
	assign digest_byte = out_byte_q;
	assign digest_last = out_last_q;

`ifndef SYNTH
	a_fill_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD || state_q == ST_ROUND) |-> fill_q == 4'd0)
		else $error("fill count not zero during compression");
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (rnd_q < 5'(ROUNDS) && step_q < 6'(STATE_BYTES)))
		else $error("round or step counter out of range");
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (step_q < 6'(BLK_BYTES) && src_q))
		else $error("digest output outside final block");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && step_q == 6'(BLK_BYTES - 1)) |=> (state_q == ST_IDLE && out_last_q))
		else $error("last digest beat did not end the message");
`endif

endmodule
